[src/sfq_pkg.sv]
package sfq_pkg;

    // queue geometry
    localparam int DEPTH  = 16;
    localparam int KEY_W  = 48;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;
    localparam int OCC_W  = 5;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_DELETE  = 2'd2,
        OP_LOOKUP  = 2'd3
    } t_op;

    // result status codes
    typedef enum logic [ST_W-1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic load;   // accepted enqueue
        logic pop;    // accepted dequeue
        logic del;    // accepted delete
    } t_cell_ctl;

endpackage

[src/sfq_if.sv]
interface sfq_in_if;
    logic                       valid;
    logic                       ready;
    logic [sfq_pkg::OP_W-1:0]   operation;
    logic [sfq_pkg::KEY_W-1:0]  key_mac;

    modport source (output valid, output operation, output key_mac, input ready);
    modport sink   (input valid, input operation, input key_mac, output ready);
endinterface

interface sfq_out_if;
    logic                       valid;
    logic                       ready;
    logic [sfq_pkg::ST_W-1:0]   status;
    logic [sfq_pkg::KEY_W-1:0]  out_mac;
    logic [sfq_pkg::OCC_W-1:0]  occupancy;
    logic                       is_empty;

    modport source (output valid, output status, output out_mac, output occupancy,
                    output is_empty, input ready);
    modport sink   (input valid, input status, input out_mac, input occupancy,
                    input is_empty, output ready);
endinterface

[src/sfq_cell.sv]
module sfq_cell (
    input  logic                      i_clk,
    input  sfq_pkg::t_cell_ctl        i_ctl,
    input  logic [sfq_pkg::KEY_W-1:0] i_key,
    input  logic                      i_occ,
    input  logic                      i_prev_occ,
    input  logic                      i_hit,
    input  logic [sfq_pkg::KEY_W-1:0] i_next_key,
    output logic                      o_hit,
    output logic [sfq_pkg::KEY_W-1:0] o_key
);
    import sfq_pkg::*;

    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] n_key;
    logic             w_match;

    // key compare, first match ripples towards the tail
    assign w_match = i_occ && (r_key == i_key);
    assign o_hit   = i_hit || w_match;
    assign o_key   = r_key;

    // next key: append at first free cell, or close up from the neighbour
    always_comb begin
        n_key = r_key;
        if (i_ctl.load && !i_occ && i_prev_occ) begin
            n_key = i_key;
        end else if (i_ctl.pop) begin
            n_key = i_next_key;
        end else if (i_ctl.del && o_hit) begin
            n_key = i_next_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

[src/searchable_fifo_queue.sv]
// Searchable first-in first-out queue of 48-bit MAC keys, holding up to DEPTH
// entries in a row of cells with the head in cell 0. Each input word carries
// one operation: enqueue (appended at the tail, no duplicate check; refused
// with status full when the queue is full), dequeue (head key returned in
// out_mac), delete (first matching entry from the head is removed and the
// later entries close up) or lookup (status done when found, miss otherwise).
// Every input word gives exactly one result word with status, out_mac (zero
// unless a dequeue succeeded), occupancy after the operation and an empty
// flag. All cells compare the key at once and the first-match flag ripples
// down the row, so a new word is taken every cycle and its result appears
// in the output register on the next cycle; the output register stalls the
// input only while a result waits to be taken.
module searchable_fifo_queue (
    input  logic i_clk,
    input  logic i_rst_n,
    sfq_in_if.sink    i_in,
    sfq_out_if.source o_out
);
    import sfq_pkg::*;

    // cell row wiring
    logic [KEY_W-1:0] w_key [DEPTH];
    logic [DEPTH:0]   w_hit;
    logic [DEPTH-1:0] w_occ;
    t_cell_ctl        w_ctl;

    logic             w_accept;
    t_op              w_op;
    logic             w_full;
    logic             w_empty;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    logic             r_out_valid;
    t_status          r_status;
    t_status          n_status;
    logic [KEY_W-1:0] r_out_mac;
    logic [KEY_W-1:0] n_out_mac;
    logic [OCC_W-1:0] r_occupancy;
    logic             r_is_empty;

    // handshake
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_op       = t_op'(i_in.operation);
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_empty    = (r_count == '0);

    // control broadcast to the cells
    always_comb begin
        w_ctl.load = w_accept && (w_op == OP_ENQUEUE);
        w_ctl.pop  = w_accept && (w_op == OP_DEQUEUE) && !w_empty;
        w_ctl.del  = w_accept && (w_op == OP_DELETE);
    end

    assign w_hit[0] = 1'b0;

    // row of cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        assign w_occ[g] = (CNT_W'(g) < r_count);

        if (g == 0) begin : g_head
            sfq_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_key      (i_in.key_mac),
                .i_occ      (w_occ[g]),
                .i_prev_occ (1'b1),
                .i_hit      (w_hit[g]),
                .i_next_key (w_key[(g + 1) % DEPTH]),
                .o_hit      (w_hit[g+1]),
                .o_key      (w_key[g])
            );
        end else if (g == DEPTH - 1) begin : g_tail
            sfq_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_key      (i_in.key_mac),
                .i_occ      (w_occ[g]),
                .i_prev_occ (w_occ[g-1]),
                .i_hit      (w_hit[g]),
                .i_next_key (w_key[g]),
                .o_hit      (w_hit[g+1]),
                .o_key      (w_key[g])
            );
        end else begin : g_mid
            sfq_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_key      (i_in.key_mac),
                .i_occ      (w_occ[g]),
                .i_prev_occ (w_occ[g-1]),
                .i_hit      (w_hit[g]),
                .i_next_key (w_key[g+1]),
                .o_hit      (w_hit[g+1]),
                .o_key      (w_key[g])
            );
        end
    end

    // occupancy and result word
    always_comb begin
        n_count   = r_count;
        n_status  = ST_DONE;
        n_out_mac = '0;
        case (w_op)
            OP_ENQUEUE: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_DEQUEUE: begin
                if (w_empty) begin
                    n_status = ST_MISS;
                end else begin
                    n_out_mac = w_key[0];
                    n_count   = r_count - CNT_W'(1);
                end
            end
            OP_DELETE: begin
                if (!w_hit[DEPTH]) begin
                    n_status = ST_MISS;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_status = w_hit[DEPTH] ? ST_DONE : ST_MISS;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status    <= n_status;
            r_out_mac   <= n_out_mac;
            r_occupancy <= OCC_W'(n_count);
            r_is_empty  <= (n_count == '0);
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.status    = r_status;
    assign o_out.out_mac   = r_out_mac;
    assign o_out.occupancy = r_occupancy;
    assign o_out.is_empty  = r_is_empty;

    // count never exceeds the row
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    // every accepted word leaves a result behind
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("accepted word produced no result");

    // refused enqueue leaves the queue untouched
    a_full_refusal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_op == OP_ENQUEUE && w_full)
        |=> (r_status == ST_FULL) && $stable(r_count))
        else $error("enqueue on full queue changed state");

    // lookup never changes occupancy
    a_lookup_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_op == OP_LOOKUP) |=> $stable(r_count))
        else $error("lookup changed occupancy");

    // empty flag agrees with occupancy
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_is_empty == (r_occupancy == '0)))
        else $error("empty flag disagrees with occupancy");

endmodule

[tb/searchable_fifo_queue_test.sv]
`timescale 1ns / 100ps

module searchable_fifo_queue_test;

    import sfq_pkg::*;

    // one result word as the queue should report it
    typedef struct packed {
        t_status                status;
        logic [KEY_W-1:0]       out_mac;
        logic [OCC_W-1:0]       occupancy;
        logic                   is_empty;
    } t_reply;

    // one row of the directed table, repeated reps times with the key stepping
    typedef struct packed {
        t_op                    op;
        logic [KEY_W-1:0]       key;
        logic [KEY_W-1:0]       key_step;
        int                     reps;
        logic                   pinned;
        t_reply                 reply;
    } t_stim_row;

    localparam logic [KEY_W-1:0] KEY_ONES   = {KEY_W{1'b1}};
    localparam logic [KEY_W-1:0] KEY_STRIDE = 48'h0101_0101_0101;
    localparam int               RANDOM_WORDS = 350;

    logic i_clk;
    logic i_rst_n;

    sfq_in_if  in_bus ();
    sfq_out_if out_bus ();

    searchable_fifo_queue uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // directed table: replies typed in only where they are obvious
    t_stim_row directed_rows [20] = '{
        '{OP_DEQUEUE, 48'h0, 48'h0, 1, 1'b1, '{ST_MISS, 48'h0, 5'd0, 1'b1}},
        '{OP_LOOKUP,  48'h0, 48'h0, 1, 1'b1, '{ST_MISS, 48'h0, 5'd0, 1'b1}},
        '{OP_DELETE,  KEY_ONES, 48'h0, 1, 1'b1, '{ST_MISS, 48'h0, 5'd0, 1'b1}},
        '{OP_ENQUEUE, KEY_ONES, 48'h0, 1, 1'b1, '{ST_DONE, 48'h0, 5'd1, 1'b0}},
        '{OP_ENQUEUE, 48'h0, 48'h0, 1, 1'b1, '{ST_DONE, 48'h0, 5'd2, 1'b0}},
        '{OP_ENQUEUE, KEY_ONES, 48'h0, 1, 1'b1, '{ST_DONE, 48'h0, 5'd3, 1'b0}},
        '{OP_LOOKUP,  48'h0, 48'h0, 1, 1'b1, '{ST_DONE, 48'h0, 5'd3, 1'b0}},
        '{OP_DELETE,  KEY_ONES, 48'h0, 1, 1'b0, '0},
        '{OP_DEQUEUE, 48'h0, 48'h0, 1, 1'b1, '{ST_DONE, 48'h0, 5'd1, 1'b0}},
        '{OP_DEQUEUE, 48'h0, 48'h0, 1, 1'b1, '{ST_DONE, KEY_ONES, 5'd0, 1'b1}},
        '{OP_ENQUEUE, 48'h1, KEY_STRIDE, 16, 1'b0, '0},
        '{OP_ENQUEUE, 48'h5, 48'h0, 1, 1'b1, '{ST_FULL, 48'h0, 5'd16, 1'b0}},
        '{OP_DELETE,  48'h0F0F_0F0F_0F10, 48'h0, 1, 1'b0, '0},
        '{OP_ENQUEUE, 48'h8000_0000_0000, 48'h0, 1, 1'b0, '0},
        '{OP_LOOKUP,  48'h8000_0000_0000, 48'h0, 1, 1'b0, '0},
        '{OP_DELETE,  48'h0707_0707_0708, 48'h0, 1, 1'b0, '0},
        '{OP_DELETE,  48'h7FFF_FFFF_FFFF, 48'h0, 1, 1'b1, '{ST_MISS, 48'h0, 5'd15, 1'b0}},
        '{OP_LOOKUP,  48'h0F0F_0F0F_0F10, 48'h0, 1, 1'b0, '0},
        '{OP_DEQUEUE, 48'h0, 48'h0, 15, 1'b0, '0},
        '{OP_DEQUEUE, 48'h0, 48'h0, 1, 1'b1, '{ST_MISS, 48'h0, 5'd0, 1'b1}}
    };

    logic [KEY_W-1:0]   held_keys [$];
    t_reply             queue_replies_due [$];
    logic [KEY_W-1:0]   key_pool [8];
    logic               pin_on;
    t_reply             pin_reply;
    int                 words_sent;
    int                 mismatch_count;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #1_000_000;
        $display("searchable_fifo_queue regression: fail");
        $finish;
    end

    // queue behaviour: apply one operation to the held keys, return the reply
    function automatic t_reply apply_queue_op(t_op op, logic [KEY_W-1:0] key);
        t_reply r;
        int     hit;
        r.status  = ST_DONE;
        r.out_mac = '0;
        hit = -1;
        for (int i = 0; i < held_keys.size(); i++) begin
            if (hit < 0 && held_keys[i] == key) hit = i;
        end
        case (op)
            OP_ENQUEUE: begin
                if (held_keys.size() >= DEPTH) r.status = ST_FULL;
                else held_keys.push_back(key);
            end
            OP_DEQUEUE: begin
                if (held_keys.size() == 0) r.status = ST_MISS;
                else r.out_mac = held_keys.pop_front();
            end
            OP_DELETE: begin
                if (hit < 0) r.status = ST_MISS;
                else held_keys.delete(hit);
            end
            default: begin
                r.status = (hit < 0) ? ST_MISS : ST_DONE;
            end
        endcase
        r.occupancy = OCC_W'(held_keys.size());
        r.is_empty  = (held_keys.size() == 0);
        return r;
    endfunction

    // watch both channels at the rising edge
    always @(posedge i_clk) begin : watch_ports
        t_reply due;
        t_reply predicted;
        if (i_rst_n) begin
            // result word against the oldest reply due
            if (out_bus.valid && out_bus.ready) begin
                if (queue_replies_due.size() == 0) begin
                    $error("result word with no operation outstanding");
                    mismatch_count++;
                end else begin
                    due = queue_replies_due.pop_front();
                    if (out_bus.status !== due.status) begin
                        $error("status: expected %0d, actual %0d", due.status, out_bus.status);
                        mismatch_count++;
                    end
                    if (out_bus.out_mac !== due.out_mac) begin
                        $error("out_mac: expected %h, actual %h", due.out_mac, out_bus.out_mac);
                        mismatch_count++;
                    end
                    if (out_bus.occupancy !== due.occupancy) begin
                        $error("occupancy: expected %0d, actual %0d",
                               due.occupancy, out_bus.occupancy);
                        mismatch_count++;
                    end
                    if (out_bus.is_empty !== due.is_empty) begin
                        $error("is_empty: expected %0d, actual %0d",
                               due.is_empty, out_bus.is_empty);
                        mismatch_count++;
                    end
                end
            end
            // accepted operation word updates the held keys
            if (in_bus.valid && in_bus.ready) begin
                predicted = apply_queue_op(t_op'(in_bus.operation), in_bus.key_mac);
                queue_replies_due.push_back(pin_on ? pin_reply : predicted);
                words_sent++;
            end
        end
    end

    // result side: random stalls, one long hold-off, one calm stretch
    initial begin : drain_side
        int hold_left;
        bit hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        out_bus.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!hold_used && words_sent >= 150) begin
                hold_used = 1'b1;
                hold_left = 64;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_bus.ready <= 1'b0;
            end else if (words_sent >= 300 && words_sent < 380) begin
                out_bus.ready <= 1'b1;
            end else begin
                out_bus.ready <= ($urandom_range(0, 99) >= 16);
            end
        end
    end

    // offer one operation word and hold it until taken
    task automatic send_word(t_op op, logic [KEY_W-1:0] key, logic pinned, t_reply reply);
        bit gaps_on;
        gaps_on = !(words_sent >= 100 && words_sent < 200);
        if (gaps_on && $urandom_range(0, 99) < 16) begin
            in_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(negedge i_clk);
        end
        in_bus.valid     <= 1'b1;
        in_bus.operation <= op;
        in_bus.key_mac   <= key;
        pin_on           <= pinned;
        pin_reply        <= reply;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // operation side
    initial begin : feed_side
        t_op              op;
        logic [KEY_W-1:0] key;
        int               pick;
        i_rst_n          = 1'b0;
        in_bus.valid     = 1'b0;
        in_bus.operation = OP_ENQUEUE;
        in_bus.key_mac   = '0;
        pin_on           = 1'b0;
        pin_reply        = '0;
        words_sent       = 0;
        mismatch_count   = 0;
        foreach (key_pool[i]) key_pool[i] = KEY_W'({$urandom(), $urandom()});

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        foreach (directed_rows[r]) begin
            for (int n = 0; n < directed_rows[r].reps; n++) begin
                send_word(directed_rows[r].op,
                          directed_rows[r].key + KEY_W'(n) * directed_rows[r].key_step,
                          directed_rows[r].pinned, directed_rows[r].reply);
            end
        end

        // random words, alternating fill-heavy and drain-heavy runs
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == 250) begin
                // let every reply drain before carrying on
                in_bus.valid <= 1'b0;
                do @(negedge i_clk); while (queue_replies_due.size() != 0);
            end
            pick = $urandom_range(0, 99);
            if ((n / 50) % 2 == 0)
                op = (pick < 50) ? OP_ENQUEUE : (pick < 65) ? OP_DEQUEUE :
                     (pick < 80) ? OP_DELETE : OP_LOOKUP;
            else
                op = (pick < 20) ? OP_ENQUEUE : (pick < 60) ? OP_DEQUEUE :
                     (pick < 80) ? OP_DELETE : OP_LOOKUP;
            // keys: held ones for hits, a small pool for duplicates, extremes, noise
            pick = $urandom_range(0, 9);
            if (op != OP_ENQUEUE && pick < 5 && held_keys.size() != 0)
                key = held_keys[$urandom_range(0, held_keys.size() - 1)];
            else if (pick < 7)
                key = key_pool[$urandom_range(0, 7)];
            else if (pick == 7)
                key = $urandom_range(0, 1) ? KEY_ONES : '0;
            else
                key = KEY_W'({$urandom(), $urandom()});
            send_word(op, key, 1'b0, '0);
        end

        // wind down
        in_bus.valid <= 1'b0;
        while (queue_replies_due.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (mismatch_count == 0 && queue_replies_due.size() == 0)
            $display("searchable_fifo_queue regression: pass");
        else
            $display("searchable_fifo_queue regression: fail");
        $finish;
    end

endmodule

[sim.f]
src/sfq_pkg.sv
src/sfq_if.sv
src/sfq_cell.sv
src/searchable_fifo_queue.sv
tb/searchable_fifo_queue_test.sv
